>>> src/mse_pkg.sv
// Package for the MIPS subset executor: opcodes, functs, sizes, result type.
// No dependencies.
package mse_pkg;
   localparam int DMEM_WORDS = 1024;
   localparam int DMEM_AW = $clog2(DMEM_WORDS);

   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_BGTZ  = 6'h07;
   localparam logic [5:0] OP_ADDI  = 6'h08;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTI  = 6'h0a;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_LUI   = 6'h0f;
   localparam logic [5:0] OP_LB    = 6'h20;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SB    = 6'h28;
   localparam logic [5:0] OP_SW    = 6'h2b;

   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_SLT  = 6'h2a;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        flag_n;
      logic        flag_z;
      logic        flag_v;
      logic        flag_c;
      logic        halted;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
   } rsp_type;
endpackage

>>> src/mse_req_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on mse_pkg.
interface mse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

interface mse_rsp_if;
   logic             valid;
   logic             ready;
   mse_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/mips_subset_instruction_executor.sv
// Top level of the MIPS subset executor.
// Depends on mse_pkg and the channel interfaces in mse_req_if.sv.
//
// Executes one MIPS32 subset instruction per instruction beat and returns one
// result beat per instruction. An accepted beat goes into the decode-stage
// registers and its result then into the output register, so a new instruction
// can be taken on every clock unless the output stalls. In the accept cycle the
// register operands and the effective address are resolved and the data memory
// read is issued, with the write back of the instruction ahead forwarded. Then,
// unless stalled, the beat executes, writes back and commits. The input is held
// off while a result waits in the output register with rsp.ready low. After
// reset the data memory is cleared by a pass over all DMEM_WORDS (1024) words,
// during which req.ready stays low. A csr write loads the program counter.
module mips_subset_instruction_executor (
   input logic clock,
   input logic reset,
   input logic csr_write_enable,
   input logic [31:0] csr_write_data,
   mse_req_if.sink req,
   mse_rsp_if.source rsp
);
   localparam int AW = mse_pkg::DMEM_AW;

   // register bank and data memory
   logic [31:0] rf_ff [32];
   logic [31:0] dm_mem [mse_pkg::DMEM_WORDS];

   // clearing pass after reset
   logic          clear_ff;
   logic [AW-1:0] clear_idx_ff;

   // decode-stage registers, loaded when a beat is accepted
   logic        s1_valid_ff;
   logic [31:0] s1_instr_ff;
   logic [31:0] s1_a_ff, s1_b_ff, s1_addr_ff;
   logic [31:0] dm_rd_ff;
   logic        dm_fw_ff;
   logic [31:0] dm_fw_data_ff;

   // architectural state
   logic [31:0] pc_ff, pc_in;
   logic [3:0]  flags_ff, flags_in;
   logic        halt_ff, halt_in;

   // output register
   logic             out_valid_ff;
   mse_pkg::rsp_type out_ff, res;

   // execute-stage write ports
   logic          rf_we;
   logic [4:0]    rf_wa;
   logic [31:0]   rf_wd;
   logic          dm_we;
   logic [AW-1:0] dm_wa;
   logic [31:0]   dm_wd;
   logic          dm_port_we;
   logic [AW-1:0] dm_port_wa;
   logic [31:0]   dm_port_wd;

   logic stall, req_fire, s2_go;
   assign stall = out_valid_ff && !rsp.ready;
   assign req.ready = !stall && !clear_ff;
   assign req_fire = req.valid && req.ready;
   assign s2_go = s1_valid_ff && !stall;

   // operands of the incoming beat, write back of the instruction ahead forwarded
   logic [4:0]    in_rs, in_rt;
   logic [31:0]   in_a, in_b, in_addr;
   logic [AW-1:0] in_idx;
   assign in_rs = req.instr_word[25:21];
   assign in_rt = req.instr_word[20:16];
   assign in_a = (rf_we && rf_wa == in_rs) ? rf_wd : rf_ff[in_rs];
   assign in_b = (rf_we && rf_wa == in_rt) ? rf_wd : rf_ff[in_rt];
   assign in_addr = in_a + {{16{req.instr_word[15]}}, req.instr_word[15:0]};
   assign in_idx = in_addr[AW+1:2];

   // execute-stage decode
   logic [5:0]    op, fn;
   logic [4:0]    rt, rd;
   logic [31:0]   a, b, imm, simm, pc4, r, addr, w_cur, w_new;
   logic [AW-1:0] addr_idx;
   logic [4:0]    sh;
   logic [32:0]   sum33;
   logic          known, wr, mw;
   logic [4:0]    widx;
   logic [31:0]   wval, npc;
   logic          n, z, v, c;

   assign op = s1_instr_ff[31:26];
   assign rt = s1_instr_ff[20:16];
   assign rd = s1_instr_ff[15:11];
   assign fn = s1_instr_ff[5:0];
   assign imm = {16'h0, s1_instr_ff[15:0]};
   assign simm = {{16{s1_instr_ff[15]}}, s1_instr_ff[15:0]};
   assign a = s1_a_ff;
   assign b = s1_b_ff;
   assign addr = s1_addr_ff;
   assign addr_idx = addr[AW+1:2];

   // memory word: a store committed in the accept cycle is forwarded
   assign w_cur = dm_fw_ff ? dm_fw_data_ff : dm_rd_ff;

   assign pc4 = pc_ff + 32'd4;
   assign sh = {addr[1:0], 3'b000};

   // execute
   always_comb begin
      known = 1'b1; wr = 1'b0; mw = 1'b0; widx = 5'd0; wval = 32'h0;
      npc = pc4; n = 1'b0; z = 1'b0; v = 1'b0; c = 1'b0;
      r = 32'h0; w_new = 32'h0; sum33 = 33'h0;
      if (op == mse_pkg::OP_RTYPE) begin
         unique case (fn)
            mse_pkg::FN_ADD, mse_pkg::FN_ADDU: begin
               sum33 = {1'b0, a} + {1'b0, b};
               r = sum33[31:0]; c = sum33[32]; z = (r == 32'h0);
               if (fn == mse_pkg::FN_ADD) begin
                  v = ~(a[31] ^ b[31]) & (a[31] ^ r[31]); n = r[31];
               end
               wr = 1'b1; widx = rd; wval = r;
            end
            mse_pkg::FN_SUB, mse_pkg::FN_SUBU: begin
               sum33 = {1'b0, a} - {1'b0, b};
               r = sum33[31:0]; c = sum33[32]; z = (r == 32'h0);
               if (fn == mse_pkg::FN_SUB) begin
                  v = (a[31] ^ b[31]) & (a[31] ^ r[31]); n = r[31];
               end
               wr = 1'b1; widx = rd; wval = r;
            end
            mse_pkg::FN_SLT: begin
               wr = 1'b1; widx = rd; wval = {31'h0, $signed(a) < $signed(b)};
            end
            mse_pkg::FN_SLTU: begin
               wr = 1'b1; widx = rd; wval = {31'h0, a < b};
            end
            default: known = 1'b0;
         endcase
      end else begin
         unique case (op)
            mse_pkg::OP_LUI: begin
               r = {s1_instr_ff[15:0], 16'h0}; z = (r == 32'h0);
               wr = 1'b1; widx = rt; wval = r;
            end
            mse_pkg::OP_ORI: begin
               r = a | imm; z = (r == 32'h0);
               wr = 1'b1; widx = rt; wval = r;
            end
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
               sum33 = {1'b0, a} + {1'b0, simm};
               r = sum33[31:0]; c = sum33[32]; z = (r == 32'h0);
               if (op == mse_pkg::OP_ADDI) begin
                  v = ~(a[31] ^ simm[31]) & (a[31] ^ r[31]); n = r[31];
               end
               wr = 1'b1; widx = rt; wval = r;
            end
            mse_pkg::OP_LW: begin
               r = w_cur; n = r[31]; z = (r == 32'h0);
               wr = 1'b1; widx = rt; wval = r;
            end
            mse_pkg::OP_LB: begin
               r = w_cur >> sh;
               r = {{24{r[7]}}, r[7:0]}; n = r[31]; z = (r == 32'h0);
               wr = 1'b1; widx = rt; wval = r;
            end
            mse_pkg::OP_SW: begin
               w_new = b; mw = 1'b1;
            end
            mse_pkg::OP_SB: begin
               w_new = (w_cur & ~(32'hff << sh)) | ({24'h0, b[7:0]} << sh);
               mw = 1'b1;
            end
            mse_pkg::OP_BNE: if (a != b) npc = pc4 + {simm[29:0], 2'b00};
            mse_pkg::OP_BEQ: if (a == b) npc = pc4 + {simm[29:0], 2'b00};
            mse_pkg::OP_BGTZ:
               if (!a[31] && a != 32'h0) npc = pc4 + {simm[29:0], 2'b00};
            mse_pkg::OP_SLTI: begin
               wr = 1'b1; widx = rt; wval = {31'h0, $signed(a) < $signed(simm)};
            end
            mse_pkg::OP_J: npc = {pc4[31:28], s1_instr_ff[25:0], 2'b00};
            mse_pkg::OP_JAL: begin
               npc = {pc4[31:28], s1_instr_ff[25:0], 2'b00};
               wr = 1'b1; widx = 5'd31; wval = pc4;
            end
            default: known = 1'b0;
         endcase
      end
      if (!known) begin
         npc = pc_ff; wr = 1'b0; mw = 1'b0;
      end
      if (widx == 5'd0) wr = 1'b0;
   end

   // result beat and next state
   always_comb begin
      res = '0;
      pc_in = pc_ff; flags_in = flags_ff; halt_in = halt_ff;
      rf_we = 1'b0; rf_wa = widx; rf_wd = wval;
      dm_we = 1'b0; dm_wa = addr_idx; dm_wd = w_new;
      if (halt_ff) begin
         res.next_pc = pc_ff;
         {res.flag_n, res.flag_z, res.flag_v, res.flag_c} = flags_ff;
         res.halted = 1'b1;
      end else begin
         res.next_pc = npc;
         {res.flag_n, res.flag_z, res.flag_v, res.flag_c} = {n, z, v, c};
         res.halted = !known;
         res.reg_write = wr;
         res.reg_index = wr ? widx : 5'd0;
         res.reg_value = wr ? wval : 32'h0;
         res.mem_write = mw;
         res.mem_address = mw ? addr : 32'h0;
         res.mem_data = mw ? w_new : 32'h0;
         if (s2_go) begin
            pc_in = npc; flags_in = {n, z, v, c}; halt_in = !known;
            rf_we = wr; dm_we = mw;
         end
      end
   end

   // data memory write port, shared with the clearing pass
   assign dm_port_we = clear_ff || dm_we;
   assign dm_port_wa = clear_ff ? clear_idx_ff : dm_wa;
   assign dm_port_wd = clear_ff ? 32'h0 : dm_wd;

   // data memory and decode-stage registers
   always_ff @(posedge clock) begin
      if (dm_port_we) dm_mem[dm_port_wa] <= dm_port_wd;
      if (req_fire) begin
         dm_rd_ff <= dm_mem[in_idx];
         dm_fw_ff <= dm_we && dm_wa == in_idx;
         dm_fw_data_ff <= dm_wd;
         s1_instr_ff <= req.instr_word;
         s1_a_ff <= in_a;
         s1_b_ff <= in_b;
         s1_addr_ff <= in_addr;
      end
      if (s2_go) out_ff <= res;
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) rf_ff[i] <= 32'h0;
      end else if (rf_we) begin
         rf_ff[rf_wa] <= rf_wd;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff <= 32'h0;
         flags_ff <= 4'h0;
         halt_ff <= 1'b0;
         clear_ff <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         if (!stall) s1_valid_ff <= req_fire;
         if (s2_go) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         pc_ff <= csr_write_enable ? csr_write_data : pc_in;
         flags_ff <= flags_in;
         halt_ff <= halt_in;
         if (clear_ff) begin
            clear_idx_ff <= clear_idx_ff + AW'(1);
            if (clear_idx_ff == AW'(mse_pkg::DMEM_WORDS - 1)) clear_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;
endmodule
